// ----- rtl/core/byte_fifo_with_purge_top_macros.svh -----
// Assertion macros used by the checker file of the byte FIFO.
`ifndef BYTE_FIFO_WITH_PURGE_TOP_MACROS_SVH
`define BYTE_FIFO_WITH_PURGE_TOP_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define BFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define BFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/bfp_pkg.sv -----
// Types and constants of the byte FIFO with purge.
`default_nettype none

package bfp_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] MODE_ENQ   = 2'd0;
    localparam logic [1:0] MODE_DEQ   = 2'd1;
    localparam logic [1:0] MODE_PURGE = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_UNF = 2'd1;
    localparam logic [1:0] STATUS_OVF = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MATCH_COUNT = 3'd0;
    localparam logic [2:0] REG_MATCH_A     = 3'd1;
    localparam logic [2:0] REG_MATCH_B     = 3'd2;
    localparam logic [2:0] REG_MATCH_C     = 3'd3;
    localparam logic [2:0] REG_MATCH_D     = 3'd4;

    // Reset values of the configuration registers
    localparam logic [2:0] MATCH_COUNT_RST = 3'd3;
    localparam logic [7:0] MATCH_A_RST     = 8'd65;
    localparam logic [7:0] MATCH_B_RST     = 8'd67;
    localparam logic [7:0] MATCH_C_RST     = 8'd69;
    localparam logic [7:0] MATCH_D_RST     = 8'd0;

    localparam int NUM_MATCH = 4;

    typedef struct packed {
        logic [2:0]                 count;
        logic [NUM_MATCH-1:0][7:0]  bytes;
    } match_cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/bfp_match.sv -----
// Compare unit shared by every purge step: tests one byte against the match set.
`default_nettype none

module bfp_match
(
    input  wire bfp_pkg::match_cfg_t cfg,
    input  wire logic [7:0]          value,
    output logic                     hit
);

    logic [bfp_pkg::NUM_MATCH-1:0] lane_hit;

    // A count of four or more enables all four lanes
    always_comb
    begin
        for (int i = 0; i < bfp_pkg::NUM_MATCH; i++)
        begin
            lane_hit[i] = (cfg.count > 3'(i)) && (cfg.bytes[i] == value);
        end
    end

    assign hit = |lane_hit;

endmodule

`default_nettype wire

// ----- rtl/core/byte_fifo_with_purge_top.sv -----
// Byte FIFO with enqueue, dequeue and filtered purge behind stream ports.
//
// Input channel s_*: s_tuser carries the operation (enqueue, dequeue, purge),
// s_tdata the byte to enqueue. Every accepted word yields exactly one result
// word on m_*: the dequeued byte (zero otherwise), a status (ok, underflow on
// an empty dequeue, overflow on a full enqueue) and the fill level afterward.
// Match bytes and their count sit in registers written through cfg_*.
// Enqueue, unused codes, a dequeue from an empty queue and a purge of an empty
// queue go straight to the result state; a dequeue first waits for the
// registered read of the slot memory. A purge walks the occupied slots
// through the single memory read port and the shared compare unit, one read
// and one compare per slot, packing each survivor back. The input is not
// ready until the result has moved into the output register. That register
// holds a result while m_tready is low; the next word is accepted meanwhile
// and its result waits inside until the register frees up. Reset empties the
// queue, reloads the match registers with their defaults and drops m_tvalid;
// slot contents are not cleared and need no clearing pass.
`default_nettype none

module byte_fifo_with_purge_top
#(
    parameter int DEPTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] push_byte
    input  wire logic [1:0]  s_tuser,    // [1:0] mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,    // [7:0] pop_byte, [9:8] status, [14:10] fill_level, [15] 0
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = CW + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL      = CW'(DEPTH);
    localparam logic [TW-1:0] RING      = TW'(DEPTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEQ  = 3'd1;
    localparam logic [2:0] ST_PRD  = 3'd2;
    localparam logic [2:0] ST_PCHK = 3'd3;
    localparam logic [2:0] ST_RES  = 3'd4;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
        ring_inc = (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [CW-1:0]       occ_reg, occ_next;
    logic [AW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       kept_reg, kept_next;
    logic [7:0]          pop_reg, pop_next;
    logic [1:0]          status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic [15:0]         out_data_reg, out_data_next;

    bfp_pkg::match_cfg_t cfg_reg;

    logic [7:0]          mem [DEPTH];
    logic [7:0]          rd_data_reg;
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    logic [7:0]          mem_wdata;

    logic [TW-1:0]       tail_sum;
    logic [AW-1:0]       tail;
    logic                hit;
    logic                accept;
    logic                out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Tail position: head plus fill, wrapped once around the ring
    assign tail_sum = TW'(head_reg) + TW'(occ_reg);
    assign tail     = (tail_sum >= RING) ? AW'(tail_sum - RING) : AW'(tail_sum);

    bfp_match u_match
    (
        .cfg   (cfg_reg),
        .value (rd_data_reg),
        .hit   (hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        idx_next       = idx_reg;
        kept_next      = kept_reg;
        pop_next       = pop_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = tail;
        mem_wdata      = s_tdata;
        mem_re         = 1'b0;
        mem_raddr      = head_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pop_next    = 8'd0;
                    status_next = bfp_pkg::STATUS_OK;
                    state_next  = ST_RES;
                    case (s_tuser)
                        bfp_pkg::MODE_ENQ:
                        begin
                            if (occ_reg == FULL)
                            begin
                                status_next = bfp_pkg::STATUS_OVF;
                            end
                            else
                            begin
                                mem_we   = 1'b1;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        bfp_pkg::MODE_DEQ:
                        begin
                            if (occ_reg == '0)
                            begin
                                status_next = bfp_pkg::STATUS_UNF;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_DEQ;
                            end
                        end
                        bfp_pkg::MODE_PURGE:
                        begin
                            if (occ_reg != '0)
                            begin
                                rd_ptr_next = head_reg;
                                wr_ptr_next = head_reg;
                                idx_next    = '0;
                                kept_next   = '0;
                                state_next  = ST_PRD;
                            end
                        end
                        default:
                        begin
                            // unused code: report only
                        end
                    endcase
                end
            end
            ST_DEQ:
            begin
                pop_next   = rd_data_reg;
                head_next  = ring_inc(head_reg);
                occ_next   = occ_reg - 1'b1;
                state_next = ST_RES;
            end
            ST_PRD:
            begin
                mem_re      = 1'b1;
                mem_raddr   = rd_ptr_reg;
                rd_ptr_next = ring_inc(rd_ptr_reg);
                idx_next    = idx_reg + 1'b1;
                state_next  = ST_PCHK;
            end
            ST_PCHK:
            begin
                // Keep a survivor by packing it at the write pointer
                mem_waddr = wr_ptr_reg;
                mem_wdata = rd_data_reg;
                if (!hit)
                begin
                    mem_we      = 1'b1;
                    wr_ptr_next = ring_inc(wr_ptr_reg);
                    kept_next   = kept_reg + 1'b1;
                end
                if (idx_reg == occ_reg)
                begin
                    occ_next   = kept_next;
                    state_next = ST_RES;
                end
                else
                begin
                    state_next = ST_PRD;
                end
            end
            ST_RES:
            begin
                // Hold the result until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, 5'(occ_reg), status_reg, pop_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_reg      <= pop_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    // Configuration registers; indexes past the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.count    <= bfp_pkg::MATCH_COUNT_RST;
            cfg_reg.bytes[0] <= bfp_pkg::MATCH_A_RST;
            cfg_reg.bytes[1] <= bfp_pkg::MATCH_B_RST;
            cfg_reg.bytes[2] <= bfp_pkg::MATCH_C_RST;
            cfg_reg.bytes[3] <= bfp_pkg::MATCH_D_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                bfp_pkg::REG_MATCH_COUNT: cfg_reg.count    <= cfg_wdata[2:0];
                bfp_pkg::REG_MATCH_A:     cfg_reg.bytes[0] <= cfg_wdata;
                bfp_pkg::REG_MATCH_B:     cfg_reg.bytes[1] <= cfg_wdata;
                bfp_pkg::REG_MATCH_C:     cfg_reg.bytes[2] <= cfg_wdata;
                bfp_pkg::REG_MATCH_D:     cfg_reg.bytes[3] <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bfp_checker.sv -----
// Port-level checks of the byte FIFO, bound to the top level.
`default_nettype none
`include "byte_fifo_with_purge_top_macros.svh"

module bfp_checker
#(
    parameter int DEPTH = 16
)
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    `BFP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")
    `BFP_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "input ready while a word is in work")
    `BFP_ASSERT(a_fill_bound, m_tvalid && DEPTH < 32 |-> m_tdata[14:10] <= 5'(DEPTH), "fill level above depth")
    `BFP_ASSERT(a_unf_empty, m_tvalid && m_tdata[9:8] == bfp_pkg::STATUS_UNF |-> m_tdata[7:0] == 8'd0 && m_tdata[14:10] == 5'd0, "underflow with data or fill")
    `BFP_ASSERT(a_ovf_full, m_tvalid && m_tdata[9:8] == bfp_pkg::STATUS_OVF |-> m_tdata[14:10] == 5'(DEPTH) && m_tdata[7:0] == 8'd0, "overflow below full")

endmodule

bind byte_fifo_with_purge_top bfp_checker #(.DEPTH(DEPTH)) u_bfp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
